FILE: sv/hqt_pkg.sv
// hqt_pkg: shared constants and the job type of the hashed q-table update block
// no dependencies; imported by every module of the block except hqt_ram
`default_nettype none

package hqt_pkg;

  // table geometry, both powers of two (STATES from 2 to 65536, ACTIONS from 2 to 128)
  localparam int STATES  = 256;
  localparam int ACTIONS = 16;
  localparam int ROW_W   = $clog2(STATES);
  localparam int COL_W   = $clog2(ACTIONS);
  localparam int ADDR_W  = ROW_W + COL_W;
  localparam int DEPTH   = STATES * ACTIONS;

  // fixed point formats
  localparam int Q_W    = 32;
  localparam int FRAC_W = 16;
  localparam int LR_W   = 17;
  localparam int ACT_W  = 8;
  localparam int CNT_W  = 3;
  localparam int IDX_W  = 8;
  localparam logic [LR_W-1:0] LR_RESET = LR_W'(6554);

  // hash constants
  localparam int HASH_MUL   = 31;
  localparam int HASH_SCALE = 1000;
  localparam int MAX_ELEMS  = 4;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic               kind;
    logic               bad;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [Q_W-1:0]     reward;
  } hqt_job_t;

endpackage

`default_nettype wire

FILE: sv/hqt_ram.sv
// hqt_ram: generic single-port ram, registered read
// no dependencies
`default_nettype none

module hqt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: sv/hqt_front.sv
// hqt_front: input register with per-element hash terms, hash fold and action check
// depends on hqt_pkg
`default_nettype none

module hqt_front import hqt_pkg::*; (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             take,
  input  wire logic                             kind,
  input  wire logic [MAX_ELEMS-1:0][Q_W-1:0]    emb,
  input  wire logic [CNT_W-1:0]                 elem_cnt,
  input  wire logic [ACT_W-1:0]                 action,
  input  wire logic [Q_W-1:0]                   reward,
  output logic                                  front_full,
  output logic                                  push,
  output hqt_job_t                              job,
  input  wire logic                             q_full
);

  localparam int MAG_W = FRAC_W + ROW_W;

  // low ROW_W bits of (|e| * 1000) >> 16; only low bits of the hash reach the row
  function automatic logic [ROW_W-1:0] hash_term(input logic [Q_W-1:0] e);
    logic [MAG_W-1:0] mag;
    logic [MAG_W-1:0] prod;
    mag  = e[Q_W-1] ? MAG_W'(~e + Q_W'(1)) : e[MAG_W-1:0];
    prod = mag * MAG_W'(HASH_SCALE);
    return prod[FRAC_W +: ROW_W];
  endfunction

  logic                             s1_vld_r, s1_vld_nxt;
  logic [MAX_ELEMS-1:0][ROW_W-1:0]  term_r;
  logic [CNT_W-1:0]                 cnt_r;
  logic                             kind_r;
  logic [ACT_W-1:0]                 act_r;
  logic [Q_W-1:0]                   rew_r;
  logic [CNT_W-1:0]                 cnt_clamped;
  logic [ROW_W-1:0]                 hash;
  logic                             bad;

  assign cnt_clamped = (elem_cnt > CNT_W'(MAX_ELEMS)) ? CNT_W'(MAX_ELEMS) : elem_cnt;

  assign push       = s1_vld_r & ~q_full;
  assign front_full = s1_vld_r & q_full;
  assign s1_vld_nxt = take | (s1_vld_r & ~push);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < MAX_ELEMS; i++) begin
        term_r[i] <= hash_term(emb[i]);
      end
      cnt_r  <= cnt_clamped;
      kind_r <= kind;
      act_r  <= action;
      rew_r  <= reward;
    end
  end

  // fold: h = h * 31 + term over the leading elements
  always_comb begin
    hash = '0;
    for (int i = 0; i < MAX_ELEMS; i++) begin
      if (CNT_W'(i) < cnt_r) begin
        hash = ROW_W'(hash * HASH_MUL) + term_r[i];
      end
    end
  end

  assign bad = act_r[ACT_W-1] | (act_r >= ACT_W'(ACTIONS));

  always_comb begin
    job        = '0;
    job.kind   = kind_r;
    job.bad    = bad;
    job.row    = hash;
    job.col    = act_r[COL_W-1:0];
    job.reward = rew_r;
  end

endmodule

`default_nettype wire

FILE: sv/hqt_queue.sv
// hqt_queue: short job queue between front and back
// depends on hqt_pkg
`default_nettype none

module hqt_queue import hqt_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire hqt_job_t job_in,
  output logic          full,
  input  wire logic     pop,
  output hqt_job_t      job_out,
  output logic          empty
);

  hqt_job_t             entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]      cnt_r, cnt_nxt;
  logic                 do_push, do_pop;

  assign full    = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign job_out = entry_r[rd_ptr_r];

  assign wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
  assign rd_ptr_nxt = do_pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + (QPTR_W+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= job_in;
    end
  end

endmodule

`default_nettype wire

FILE: sv/hqt_back.sv
// hqt_back: table clear after reset, read or read-modify-write of one q entry per job, result register
// depends on hqt_pkg and hqt_ram
`default_nettype none

module hqt_back import hqt_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [LR_W-1:0]   lr,
  input  wire logic              q_empty,
  output logic                   q_pop,
  input  wire hqt_job_t          q_job,
  output logic                   clr_busy,
  output logic                   res_valid,
  input  wire logic              res_pop,
  output logic [Q_W-1:0]         res_q,
  output logic [IDX_W-1:0]       res_idx,
  output logic                   res_bad
);

  localparam int PROD_W = Q_W + 1 + LR_W + 1;
  localparam int STEP_W = PROD_W + 1 - FRAC_W;
  localparam int NQ_W   = STEP_W + 1;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_READ, ST_WRITE} state_t;

  state_t                   state_r, state_nxt;
  logic [ADDR_W-1:0]        clr_idx_r, clr_idx_nxt;
  hqt_job_t                 job_r, job_nxt;
  logic [Q_W-1:0]           q_r, q_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic                     out_vld_r, out_vld_nxt;
  logic [Q_W-1:0]           out_q_r, out_q_nxt;
  logic [IDX_W-1:0]         out_idx_r, out_idx_nxt;
  logic                     out_bad_r, out_bad_nxt;

  logic                     ram_en, ram_we;
  logic [ADDR_W-1:0]        ram_addr;
  logic [Q_W-1:0]           ram_wdata, ram_rdata;

  logic                     issue;
  logic signed [Q_W:0]      diff;
  logic [PROD_W:0]          rnd;
  logic [STEP_W-1:0]        step;
  logic [NQ_W-1:0]          nq;
  logic [NQ_W-Q_W:0]        nq_hi;
  logic [Q_W-1:0]           nq_sat;

  hqt_ram #(.WIDTH(Q_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign issue = (state_r == ST_IDLE) & ~q_empty & (~out_vld_r | res_pop);
  assign q_pop = issue;

  // update datapath: diff * lr, then round half up, add, saturate
  assign diff = $signed({job_r.reward[Q_W-1], job_r.reward})
              - $signed({ram_rdata[Q_W-1], ram_rdata});
  assign rnd  = {prod_r[PROD_W-1], prod_r} + (PROD_W+1)'(1 << (FRAC_W - 1));
  assign step = rnd[PROD_W:FRAC_W];
  assign nq   = {{(NQ_W-Q_W){q_r[Q_W-1]}}, q_r} + {step[STEP_W-1], step};
  assign nq_hi = nq[NQ_W-1:Q_W-1];

  always_comb begin
    if ((&nq_hi) || (~|nq_hi)) begin
      nq_sat = nq[Q_W-1:0];
    end else if (nq[NQ_W-1]) begin
      nq_sat = {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      nq_sat = {1'b0, {(Q_W-1){1'b1}}};
    end
  end

  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    job_nxt     = job_r;
    q_nxt       = q_r;
    prod_nxt    = prod_r;
    out_vld_nxt = out_vld_r & ~res_pop;
    out_q_nxt   = out_q_r;
    out_idx_nxt = out_idx_r;
    out_bad_nxt = out_bad_r;
    ram_en      = 1'b0;
    ram_we      = 1'b0;
    ram_addr    = {job_r.row, job_r.col};
    ram_wdata   = nq_sat;

    case (state_r)
      ST_CLEAR: begin
        ram_en      = 1'b1;
        ram_we      = 1'b1;
        ram_addr    = clr_idx_r;
        ram_wdata   = '0;
        clr_idx_nxt = clr_idx_r + ADDR_W'(1);
        if (clr_idx_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (issue) begin
          ram_en    = 1'b1;
          ram_addr  = {q_job.row, q_job.col};
          job_nxt   = q_job;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        q_nxt    = ram_rdata;
        prod_nxt = diff * $signed({1'b0, lr});
        if (job_r.kind && !job_r.bad) begin
          state_nxt = ST_WRITE;
        end else begin
          out_vld_nxt = 1'b1;
          out_q_nxt   = job_r.bad ? '0 : ram_rdata;
          out_idx_nxt = IDX_W'(job_r.row);
          out_bad_nxt = job_r.bad;
          state_nxt   = ST_IDLE;
        end
      end
      ST_WRITE: begin
        ram_en      = 1'b1;
        ram_we      = 1'b1;
        out_vld_nxt = 1'b1;
        out_q_nxt   = nq_sat;
        out_idx_nxt = IDX_W'(job_r.row);
        out_bad_nxt = 1'b0;
        state_nxt   = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_idx_r <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
      out_vld_r <= out_vld_nxt;
    end
    job_r     <= job_nxt;
    q_r       <= q_nxt;
    prod_r    <= prod_nxt;
    out_q_r   <= out_q_nxt;
    out_idx_r <= out_idx_nxt;
    out_bad_r <= out_bad_nxt;
  end

  assign clr_busy  = (state_r == ST_CLEAR);
  assign res_valid = out_vld_r;
  assign res_q     = out_q_r;
  assign res_idx   = out_idx_r;
  assign res_bad   = out_bad_r;

endmodule

`default_nettype wire

FILE: sv/hashed_q_table_update.sv
// hashed q-table update, top level: learning rate register, front, job queue, back
// hashed_q_table_update
//
// input side is a queue: a beat is taken when in_push is high and in_full low.
// each beat hashes up to four q15.16 embedding elements to a table row, picks
// the column from in_action and either reads the stored q value (in_kind 0) or
// moves it toward in_reward by the learning rate and stores it (in_kind 1).
// result side is a queue as well: while out_empty is low the oldest result sits
// on the out_ ports and is taken by out_pop. one result per input beat, in order.
// an out-of-range action leaves the table alone and returns 0 with out_bad_action.
// throughput is set by the single table port in the back end: a read holds it
// through the idle and read states and an update (read, multiply, write) through
// idle, read and write; a new job is issued only from the idle state.
// the front end hashes the next beats meanwhile, up to a 4-job queue plus one
// register stage, so outside the clearing pass in_full only rises when that backlog is full.
// when out_pop stays low the one result register holds and the back end stops;
// the queue then fills and in_full goes high.
// reset (rst_n low, synchronous) sets the learning rate to 6554 (about 0.1) and
// starts a clearing pass that zeroes all 4096 entries, one a cycle; in_full is
// high for the whole pass. cfg_we writes cfg_learning_rate; write it only idle.
`default_nettype none

module hashed_q_table_update import hqt_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // configuration
  input  wire logic                cfg_we,
  input  wire logic [LR_W-1:0]     cfg_learning_rate,
  // input channel
  input  wire logic                in_push,
  output logic                     in_full,
  input  wire logic                in_kind,
  input  wire logic signed [Q_W-1:0] in_embedding_0,
  input  wire logic signed [Q_W-1:0] in_embedding_1,
  input  wire logic signed [Q_W-1:0] in_embedding_2,
  input  wire logic signed [Q_W-1:0] in_embedding_3,
  input  wire logic [CNT_W-1:0]    in_element_count,
  input  wire logic signed [ACT_W-1:0] in_action,
  input  wire logic signed [Q_W-1:0] in_reward,
  // result channel
  output logic                     out_empty,
  input  wire logic                out_pop,
  output logic signed [Q_W-1:0]    out_q_value,
  output logic [IDX_W-1:0]         out_state_index,
  output logic                     out_bad_action
);

  logic [LR_W-1:0]               lr_r, lr_nxt;
  logic                          in_take;
  logic                          front_full;
  logic                          clr_busy;
  logic [MAX_ELEMS-1:0][Q_W-1:0] emb;

  // front to queue, queue to back
  logic                          fq_push;
  hqt_job_t                      fq_job;
  logic                          q_full;
  logic                          q_empty;
  logic                          q_pop;
  hqt_job_t                      q_job;

  logic                          res_valid;
  logic [Q_W-1:0]                res_q;

  // learning rate register, unsigned q1.16
  assign lr_nxt = cfg_we ? cfg_learning_rate : lr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r <= LR_RESET;
    end else begin
      lr_r <= lr_nxt;
    end
  end

  // no beats while the table is being cleared
  assign in_full = front_full | clr_busy;
  assign in_take = in_push & ~in_full;

  assign emb[0] = in_embedding_0;
  assign emb[1] = in_embedding_1;
  assign emb[2] = in_embedding_2;
  assign emb[3] = in_embedding_3;

  hqt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (in_take),
    .kind       (in_kind),
    .emb        (emb),
    .elem_cnt   (in_element_count),
    .action     (in_action),
    .reward     (in_reward),
    .front_full (front_full),
    .push       (fq_push),
    .job        (fq_job),
    .q_full     (q_full)
  );

  hqt_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (fq_push),
    .job_in  (fq_job),
    .full    (q_full),
    .pop     (q_pop),
    .job_out (q_job),
    .empty   (q_empty)
  );

  hqt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .lr        (lr_r),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_job     (q_job),
    .clr_busy  (clr_busy),
    .res_valid (res_valid),
    .res_pop   (out_pop),
    .res_q     (res_q),
    .res_idx   (out_state_index),
    .res_bad   (out_bad_action)
  );

  assign out_empty   = ~res_valid;
  assign out_q_value = res_q;

endmodule

`default_nettype wire
